// ----- rtl/mbsac_pkg.sv -----
package mbsac_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [31:0] value;
      logic        end_of_run;
   } rsp_type;

   // Records caused by one input byte: the first always exists when pushed.
   typedef struct packed {
      rsp_type rec_a;
      rsp_type rec_b;
      logic    has_b;
   } bundle_type;

   localparam logic [2:0] KIND_MDAT      = 3'd0;
   localparam logic [2:0] KIND_TIMESCALE = 3'd1;
   localparam logic [2:0] KIND_SPS       = 3'd2;
   localparam logic [2:0] KIND_PPS       = 3'd3;
   localparam logic [2:0] KIND_STATUS    = 3'd4;

   localparam logic [31:0] STATUS_FAIL = 32'd0;
   localparam logic [31:0] STATUS_OK   = 32'd1;

   localparam logic [31:0] TAG_MDAT    = 32'h6D646174;
   localparam logic [31:0] TAG_AVCC    = 32'h61766343;
   localparam logic [31:0] TAG_MDHD    = 32'h6D646864;
   localparam logic [7:0]  AVC_VERSION = 8'h01;

   localparam logic [15:0] MDHD_TOTAL_V1   = 16'(3 + 8 + 8 + 4);
   localparam logic [15:0] MDHD_TOTAL_V0   = 16'(3 + 4 + 4 + 4);
   localparam logic [15:0] SCALE_BYTES     = 16'd4;
   localparam logic [15:0] AVC_HEADER_SKIP = 16'd5;
   localparam logic [15:0] LEN_BYTES       = 16'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

endpackage

// ----- rtl/mbsac_front.sv -----
module mbsac_front
   import mbsac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   output logic       push,
   output bundle_type push_data
);

   typedef enum logic [8:0] {
      PH_SCAN    = 9'b000000001,
      PH_MDHD    = 9'b000000010,
      PH_HDR     = 9'b000000100,
      PH_SPS_LEN = 9'b000001000,
      PH_SPS     = 9'b000010000,
      PH_PPS_NUM = 9'b000100000,
      PH_PPS_LEN = 9'b001000000,
      PH_PPS     = 9'b010000000,
      PH_DONE    = 9'b100000000
   } phase_type;

   logic [31:0] tag_ff, tag_in;
   logic [39:0] avc_ff, avc_in;
   logic [31:0] pos_ff, pos_in;
   logic        mdat_seen_ff, mdat_seen_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] dc_ff, dc_in;
   logic [31:0] acc_ff, acc_in;
   logic        avc_done_ff, avc_done_in;

   logic [7:0]  b;
   logic        eof;
   logic [15:0] dc_dec;
   logic        have_mdat, have_rec, mdat_kept, avc_hit;
   rsp_type     mdat_rec, main_rec, status_rec;

   assign b      = req_data.data_byte;
   assign eof    = req_data.end_of_file;
   assign dc_dec = dc_ff - 16'd1;

   always_comb begin
      tag_in       = tag_ff;
      avc_in       = avc_ff;
      pos_in       = pos_ff;
      mdat_seen_in = mdat_seen_ff;
      phase_in     = phase_ff;
      dc_in        = dc_ff;
      acc_in       = acc_ff;
      avc_done_in  = avc_done_ff;
      have_mdat    = 1'b0;
      have_rec     = 1'b0;
      avc_hit      = 1'b0;
      main_rec     = '0;

      if (accept) begin
         pos_in = pos_ff + 32'd1;
         if (!mdat_seen_ff) begin
            tag_in = {tag_ff[23:0], b};
            if (tag_in == TAG_MDAT) begin
               mdat_seen_in = 1'b1;
               have_mdat    = 1'b1;
            end
         end

         unique case (phase_ff)
            PH_SCAN: begin
               avc_in = {avc_ff[31:0], b};
               if (avc_in[39:8] == TAG_AVCC && avc_in[7:0] == AVC_VERSION) begin
                  avc_hit     = 1'b1;
                  avc_done_in = 1'b1;
                  phase_in    = PH_HDR;
                  dc_in       = AVC_HEADER_SKIP;
               end else if (avc_in[39:8] == TAG_MDHD) begin
                  phase_in = PH_MDHD;
                  dc_in    = (avc_in[7:0] != 8'd0) ? MDHD_TOTAL_V1 : MDHD_TOTAL_V0;
                  acc_in   = '0;
               end
            end
            PH_MDHD: begin
               // Only the last four bytes of the box header form the timescale.
               if (dc_ff <= SCALE_BYTES) begin
                  acc_in = {acc_ff[23:0], b};
               end
               dc_in = dc_dec;
               if (dc_dec == 16'd0) begin
                  have_rec             = 1'b1;
                  main_rec.record_kind = KIND_TIMESCALE;
                  main_rec.value       = acc_in;
                  phase_in             = PH_SCAN;
               end
            end
            PH_HDR: begin
               dc_in = dc_dec;
               if (dc_dec == 16'd0) begin
                  phase_in = PH_SPS_LEN;
                  dc_in    = LEN_BYTES;
                  acc_in   = '0;
               end
            end
            PH_SPS_LEN, PH_PPS_LEN: begin
               acc_in = {16'd0, acc_ff[7:0], b};
               dc_in  = dc_dec;
               if (dc_dec == 16'd0) begin
                  dc_in = acc_in[15:0];
                  if (phase_ff == PH_SPS_LEN) begin
                     phase_in = (acc_in[15:0] != 16'd0) ? PH_SPS : PH_PPS_NUM;
                  end else begin
                     phase_in = (acc_in[15:0] != 16'd0) ? PH_PPS : PH_DONE;
                  end
               end
            end
            PH_SPS, PH_PPS: begin
               dc_in                = dc_dec;
               have_rec             = 1'b1;
               main_rec.record_kind = (phase_ff == PH_SPS) ? KIND_SPS : KIND_PPS;
               main_rec.value       = {24'd0, b};
               main_rec.end_of_run  = (dc_dec == 16'd0);
               if (dc_dec == 16'd0) begin
                  phase_in = (phase_ff == PH_SPS) ? PH_PPS_NUM : PH_DONE;
               end
            end
            PH_PPS_NUM: begin
               phase_in = PH_PPS_LEN;
               dc_in    = LEN_BYTES;
               acc_in   = '0;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         // The final byte starts a new file afterwards.
         if (eof) begin
            tag_in       = '0;
            avc_in       = '0;
            pos_in       = '0;
            mdat_seen_in = 1'b0;
            phase_in     = PH_SCAN;
            dc_in        = '0;
            acc_in       = '0;
            avc_done_in  = 1'b0;
         end
      end
   end

   always_comb begin
      mdat_rec.record_kind   = KIND_MDAT;
      mdat_rec.value         = pos_ff + 32'd1;
      mdat_rec.end_of_run    = 1'b0;
      status_rec.record_kind = KIND_STATUS;
      status_rec.value       = ((mdat_seen_ff || have_mdat) && (avc_done_ff || avc_hit))
                               ? STATUS_OK : STATUS_FAIL;
      status_rec.end_of_run  = 1'b1;

      // When three records fall on one byte, the mdat offset is dropped.
      mdat_kept = have_mdat && !(eof && have_rec);

      push = accept && (mdat_kept || have_rec || eof);
      if (mdat_kept) begin
         push_data.rec_a = mdat_rec;
         push_data.rec_b = have_rec ? main_rec : status_rec;
      end else begin
         push_data.rec_a = have_rec ? main_rec : status_rec;
         push_data.rec_b = status_rec;
      end
      push_data.has_b = (mdat_kept && (have_rec || eof)) || (have_rec && eof);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= '0;
         avc_ff       <= '0;
         pos_ff       <= '0;
         mdat_seen_ff <= 1'b0;
         phase_ff     <= PH_SCAN;
         dc_ff        <= '0;
         acc_ff       <= '0;
         avc_done_ff  <= 1'b0;
      end else begin
         tag_ff       <= tag_in;
         avc_ff       <= avc_in;
         pos_ff       <= pos_in;
         mdat_seen_ff <= mdat_seen_in;
         phase_ff     <= phase_in;
         dc_ff        <= dc_in;
         acc_ff       <= acc_in;
         avc_done_ff  <= avc_done_in;
      end
   end

endmodule

// ----- rtl/mbsac_queue.sv -----
module mbsac_queue
   import mbsac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type pop_data,
   output logic       empty
);

   bundle_type mem_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/mbsac_back.sv -----
module mbsac_back
   import mbsac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  bundle_type q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    pend_ff, pend_in;
   rsp_type held_ff, held_in;
   logic    load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The output register takes a new record whenever it is empty or its transfer completes.
   assign load  = !rsp_valid_ff || rsp_ready;
   assign q_pop = load && !pend_ff && !q_empty;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      held_in      = held_ff;
      if (load) begin
         if (pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = held_ff;
            pend_in      = 1'b0;
         end else if (!q_empty) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = q_data.rec_a;
            pend_in      = q_data.has_b;
            held_in      = q_data.rec_b;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      held_ff     <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

// ----- rtl/mp4_box_scan_avc_config.sv -----
// A record is written into the queue with the byte that causes it, then moves into the output
// register and is presented on rsp from there; a stalled receiver or earlier records can delay it.
// Throughput: one byte per cycle while the queue is not full; a byte that yields two records
// sends them in turn, and a four-entry queue between parser and output stage absorbs that.
// Reset: synchronous, active high; the parser returns to tag scanning with all counters,
// windows and flags cleared, and the queue and output register are emptied.
module mp4_box_scan_avc_config
   import mbsac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       accept;
   logic       push, pop, full, empty;
   bundle_type push_data, pop_data;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   mbsac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data)
   );

   mbsac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   mbsac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/mp4_box_scan_avc_config_tb.sv -----
module mp4_box_scan_avc_config_tb;
   import mbsac_pkg::*;

   typedef enum logic [3:0] {
      SCAN_TAGS, MDHD_FIELDS, AVC_HEADER, SPS_LENGTH, SPS_BYTES,
      PPS_COUNT, PPS_LENGTH, PPS_BYTES, AVC_FINISHED
   } scan_phase_type;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BYTES = 975;
   localparam int MAX_SET_BYTES = 48;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   mp4_box_scan_avc_config i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Scanner state as the block should hold it.
   logic [31:0]    tag_win;
   logic [39:0]    avc_win;
   logic [31:0]    byte_pos;
   logic           mdat_found;
   logic           avc_found;
   scan_phase_type phase;
   logic [15:0]    down_cnt;
   logic [31:0]    accum;

   rsp_type     pending_records[$];
   logic [7:0]  file_buf[$];
   int          mismatch_count = 0;
   int          bytes_sent = 0;
   bit          steady = 1'b0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic void clear_scanner();
      tag_win = '0;
      avc_win = '0;
      byte_pos = '0;
      mdat_found = 1'b0;
      avc_found = 1'b0;
      phase = SCAN_TAGS;
      down_cnt = '0;
      accum = '0;
   endfunction

   function automatic void expect_record(input rsp_type r);
      pending_records.insert(pending_records.size(), r);
   endfunction

   // Works out the records that one transferred byte causes and queues them.
   function automatic void scan_byte(input req_type item);
      logic [7:0] b;
      logic       mdat_hit;
      logic       rec_hit;
      rsp_type    mdat_rec;
      rsp_type    rec;
      rsp_type    status_rec;
      b = item.data_byte;
      mdat_hit = 1'b0;
      rec_hit = 1'b0;
      mdat_rec = '0;
      rec = '0;
      byte_pos = byte_pos + 32'd1;

      if (!mdat_found) begin
         tag_win = {tag_win[23:0], b};
         if (tag_win == TAG_MDAT) begin
            mdat_found = 1'b1;
            mdat_hit = 1'b1;
            mdat_rec.record_kind = KIND_MDAT;
            mdat_rec.value = byte_pos;
            mdat_rec.end_of_run = 1'b0;
         end
      end

      case (phase)
         SCAN_TAGS: begin
            avc_win = {avc_win[31:0], b};
            if (avc_win[39:8] == TAG_AVCC && avc_win[7:0] == AVC_VERSION) begin
               avc_found = 1'b1;
               phase = AVC_HEADER;
               down_cnt = AVC_HEADER_SKIP;
            end else if (avc_win[39:8] == TAG_MDHD) begin
               phase = MDHD_FIELDS;
               down_cnt = (avc_win[7:0] != 8'd0) ? MDHD_TOTAL_V1 : MDHD_TOTAL_V0;
               accum = '0;
            end
         end
         MDHD_FIELDS: begin
            if (down_cnt <= SCALE_BYTES) accum = {accum[23:0], b};
            down_cnt = down_cnt - 16'd1;
            if (down_cnt == 16'd0) begin
               rec_hit = 1'b1;
               rec.record_kind = KIND_TIMESCALE;
               rec.value = accum;
               rec.end_of_run = 1'b0;
               phase = SCAN_TAGS;
            end
         end
         AVC_HEADER: begin
            down_cnt = down_cnt - 16'd1;
            if (down_cnt == 16'd0) begin
               phase = SPS_LENGTH;
               down_cnt = LEN_BYTES;
               accum = '0;
            end
         end
         SPS_LENGTH, PPS_LENGTH: begin
            accum = {16'd0, accum[7:0], b};
            down_cnt = down_cnt - 16'd1;
            if (down_cnt == 16'd0) begin
               down_cnt = accum[15:0];
               if (phase == SPS_LENGTH) phase = (down_cnt != 16'd0) ? SPS_BYTES : PPS_COUNT;
               else phase = (down_cnt != 16'd0) ? PPS_BYTES : AVC_FINISHED;
            end
         end
         SPS_BYTES, PPS_BYTES: begin
            down_cnt = down_cnt - 16'd1;
            rec_hit = 1'b1;
            rec.record_kind = (phase == SPS_BYTES) ? KIND_SPS : KIND_PPS;
            rec.value = {24'd0, b};
            rec.end_of_run = (down_cnt == 16'd0);
            if (down_cnt == 16'd0) phase = (phase == SPS_BYTES) ? PPS_COUNT : AVC_FINISHED;
         end
         PPS_COUNT: begin
            phase = PPS_LENGTH;
            down_cnt = LEN_BYTES;
            accum = '0;
         end
         default: phase = AVC_FINISHED;
      endcase

      // Only two records fit on one byte, so the final byte drops its mdat offset
      // when it also carries another record.
      if (mdat_hit && !(item.end_of_file && rec_hit)) expect_record(mdat_rec);
      if (rec_hit) expect_record(rec);
      if (item.end_of_file) begin
         status_rec.record_kind = KIND_STATUS;
         status_rec.value = (mdat_found && avc_found) ? STATUS_OK : STATUS_FAIL;
         status_rec.end_of_run = 1'b1;
         expect_record(status_rec);
         clear_scanner();
      end
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Prediction and checking share one process, so a transfer on either side
   // is seen in a fixed order.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) scan_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (pending_records.size() == 0) begin
               flag_mismatch($sformatf("record kind %0d value %0h with none expected",
                                       rsp_data.record_kind, rsp_data.value));
            end else begin
               want = pending_records[0];
               pending_records.delete(0);
               if (rsp_data.record_kind !== want.record_kind)
                  flag_mismatch($sformatf("record_kind %0d, want %0d",
                                          rsp_data.record_kind, want.record_kind));
               if (rsp_data.value !== want.value)
                  flag_mismatch($sformatf("value %0h, want %0h (kind %0d)",
                                          rsp_data.value, want.value, want.record_kind));
               if (rsp_data.end_of_run !== want.end_of_run)
                  flag_mismatch($sformatf("end_of_run %0b, want %0b (kind %0d)",
                                          rsp_data.end_of_run, want.end_of_run,
                                          want.record_kind));
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      if (!steady && $urandom_range(99) < 12) begin
         gap = $urandom_range(4, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, end_of_file: eof};
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
      file_buf.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
   endtask

   function automatic void add_byte(input logic [7:0] v);
      file_buf.insert(file_buf.size(), v);
   endfunction

   function automatic void append_tag(input logic [31:0] tag);
      add_byte(tag[31:24]);
      add_byte(tag[23:16]);
      add_byte(tag[15:8]);
      add_byte(tag[7:0]);
   endfunction

   // Random bytes, leaning toward tag letters so that partial tags turn up.
   function automatic void append_noise(input int count);
      logic [7:0] letters[9] = '{8'h6D, 8'h64, 8'h61, 8'h74, 8'h68,
                                 8'h76, 8'h63, 8'h43, AVC_VERSION};
      repeat (count)
         add_byte(($urandom_range(3) == 0) ? letters[$urandom_range(8)]
                                           : 8'($urandom_range(255)));
   endfunction

   function automatic logic [15:0] pick_set_length();
      int r;
      r = $urandom_range(19);
      if (r < 2) return 16'd0;
      if (r == 2) return 16'($urandom_range(65535, 64));
      return 16'($urandom_range(12, 1));
   endfunction

   // A length beyond what is appended leaves the set cut short by the end of file.
   function automatic void append_param_set(input logic [15:0] len);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      append_noise((len > MAX_SET_BYTES) ? 8 : int'(len));
   endfunction

   function automatic void append_mdhd();
      logic [7:0] version;
      version = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 1));
      append_tag(TAG_MDHD);
      add_byte(version);
      append_noise((version != 8'd0) ? 19 : 11);
      repeat (4) add_byte(8'($urandom_range(255)));
   endfunction

   function automatic void append_avcc(input bit intact, input logic [15:0] sps_len);
      append_tag(TAG_AVCC);
      add_byte((!intact && $urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                   : AVC_VERSION);
      append_noise(5);
      append_param_set(sps_len);
      add_byte(8'($urandom_range(255)));
      append_param_set(pick_set_length());
   endfunction

   function automatic void build_random_file();
      int cut;
      append_noise($urandom_range(6));
      repeat ($urandom_range(2)) append_mdhd();
      if ($urandom_range(2) == 0) append_tag(TAG_MDAT);
      if ($urandom_range(9) != 0) append_avcc(1'b0, pick_set_length());
      if ($urandom_range(1)) append_tag(TAG_MDAT);
      append_noise($urandom_range(4));
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(file_buf.size(), 1);
         while (file_buf.size() > cut) void'(file_buf.pop_back());
      end
      if (file_buf.size() == 0) add_byte(8'($urandom_range(255)));
   endfunction

   // The closing 't' of 'mdat' is also the last SPS byte and the end of file.
   task automatic test_three_records_on_last_byte();
      append_tag(TAG_AVCC);
      add_byte(AVC_VERSION);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'h80);
      add_byte(8'h7F);
      add_byte(8'h01);
      append_param_set(16'd4);
      void'(file_buf.pop_back());
      void'(file_buf.pop_back());
      void'(file_buf.pop_back());
      void'(file_buf.pop_back());
      append_tag(TAG_MDAT);
      send_file();
   endtask

   task automatic test_short_files();
      append_tag(TAG_MDAT);
      send_file();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   // The sender keeps offering SPS bytes while the receiver holds off, so the
   // block's queue fills and it must stall its input.
   task automatic test_receiver_holdoff();
      steady = 1'b1;
      hold_requests++;
      append_avcc(1'b1, 16'd40);
      append_tag(TAG_MDAT);
      send_file();
      steady = 1'b0;
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      repeat (3) begin
         build_random_file();
         send_file();
      end
      steady = 1'b0;
   endtask

   task automatic test_random_files();
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(9) == 0) append_noise($urandom_range(40, 1));
         else build_random_file();
         send_file();
         if ($urandom_range(7) == 0) wait_drained();
      end
   endtask

   initial begin
      clear_scanner();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_three_records_on_last_byte();
      wait_drained();
      test_short_files();
      wait_drained();
      test_receiver_holdoff();
      wait_drained();
      test_steady_stream();
      wait_drained();
      test_random_files();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
